// ===== rtl/bc1td_pkg.sv =====
`timescale 1ns / 1ps

package bc1td_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_W    = 10;
  localparam int unsigned PROD_W   = 20;
  localparam logic [NUM_W-1:0] RECIP3 = 10'd683;
  localparam int unsigned RECIP3_SHIFT = 11;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    SEL_C0  = 2'd0,
    SEL_C1  = 2'd1,
    SEL_MIX = 2'd2,
    SEL_ALT = 2'd3
  } sel_e;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_DIV3 = 2'd1,
    KIND_DIV2 = 2'd2,
    KIND_ZERO = 2'd3
  } kind_e;

  typedef struct packed {
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
  } rgb_t;

  typedef struct packed {
    logic present;
    logic four_mode;
    sel_e sel;
    rgb_t e0;
    rgb_t e1;
  } expand_t;

  typedef struct packed {
    kind_e            kind;
    logic [NUM_W-1:0] b;
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] g;
  } blend_t;

  typedef struct packed {
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] a;
  } texel_t;

endpackage

// ===== rtl/bc1_texel_decode_core.sv =====
// three register stages: an accepted item is registered in expand, then blend, then scale, which drives the outputs
// throughput: one item per cycle while out_ready_i is high, set by the three register stages (expand, blend, scale)
// each stage holds one item and refills as soon as its successor takes it
// reset: rst_ni asynchronous active low, clears the stage valid bits only
`timescale 1ns / 1ps

module bc1_texel_decode_core import bc1td_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        block_present_i,
  input  logic [15:0] endpoint_a_i,
  input  logic [15:0] endpoint_b_i,
  input  logic [31:0] index_bits_i,
  input  logic [1:0]  texel_col_i,
  input  logic [1:0]  texel_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  alpha_out_o
);

  logic    s1_valid, s1_ready;
  expand_t s1_data;
  logic    s2_valid, s2_ready;
  blend_t  s2_data;
  texel_t  s3_data;

  bc1td_expand u_expand (
    .clk_i,
    .rst_ni,
    .valid_i         (in_valid_i),
    .ready_o         (in_ready_o),
    .block_present_i,
    .endpoint_a_i,
    .endpoint_b_i,
    .index_bits_i,
    .texel_col_i,
    .texel_row_i,
    .valid_o         (s1_valid),
    .ready_i         (s1_ready),
    .data_o          (s1_data)
  );

  bc1td_blend u_blend (
    .clk_i,
    .rst_ni,
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  bc1td_scale u_scale (
    .clk_i,
    .rst_ni,
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (s3_data)
  );

  assign blue_out_o  = s3_data.b;
  assign red_out_o   = s3_data.r;
  assign green_out_o = s3_data.g;
  assign alpha_out_o = s3_data.a;

`ifndef SYNTH
  a_alpha_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alpha_out_o == 8'h00 || alpha_out_o == 8'hFF))
    else $error("alpha is neither opaque nor transparent");

  a_transparent_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alpha_out_o == 8'h00) |->
      (blue_out_o == 8'h00 && red_out_o == 8'h00 && green_out_o == 8'h00))
    else $error("transparent texel is not black");

  a_stall_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid && s2_valid && out_valid_o && !out_ready_i))
    else $error("input stalled with a free stage");

  a_no_bubble_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && !s2_ready) |=> s2_valid)
    else $error("blend stage dropped an item");
`endif

endmodule

// ===== rtl/bc1td_expand.sv =====
`timescale 1ns / 1ps

module bc1td_expand import bc1td_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        block_present_i,
  input  logic [15:0] endpoint_a_i,
  input  logic [15:0] endpoint_b_i,
  input  logic [31:0] index_bits_i,
  input  logic [1:0]  texel_col_i,
  input  logic [1:0]  texel_row_i,
  output logic        valid_o,
  input  logic        ready_i,
  output expand_t     data_o
);

  function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  logic    valid_q;
  expand_t data_d, data_q;
  logic    load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    data_d.present   = block_present_i;
    data_d.four_mode = endpoint_a_i > endpoint_b_i;
    data_d.sel       = sel_e'(index_bits_i[{texel_row_i, texel_col_i, 1'b0} +: 2]);
    data_d.e0.b      = widen5(endpoint_a_i[4:0]);
    data_d.e0.r      = widen5(endpoint_a_i[15:11]);
    data_d.e0.g      = widen6(endpoint_a_i[10:5]);
    data_d.e1.b      = widen5(endpoint_b_i[4:0]);
    data_d.e1.r      = widen5(endpoint_b_i[15:11]);
    data_d.e1.g      = widen6(endpoint_b_i[10:5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/bc1td_blend.sv =====
`timescale 1ns / 1ps

module bc1td_blend import bc1td_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  expand_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output blend_t  data_o
);

  function automatic logic [NUM_W-1:0] ext(input logic [CHAN_W-1:0] v);
    return {{(NUM_W-CHAN_W){1'b0}}, v};
  endfunction

  function automatic logic [NUM_W-1:0] dbl(input logic [CHAN_W-1:0] v);
    return {{(NUM_W-CHAN_W-1){1'b0}}, v, 1'b0};
  endfunction

  logic   valid_q;
  blend_t data_d, data_q;
  logic   load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    data_d.kind = KIND_ZERO;
    data_d.b    = '0;
    data_d.r    = '0;
    data_d.g    = '0;
    if (data_i.present) begin
      case (data_i.sel)
        SEL_C0: begin
          data_d.kind = KIND_PASS;
          data_d.b    = ext(data_i.e0.b);
          data_d.r    = ext(data_i.e0.r);
          data_d.g    = ext(data_i.e0.g);
        end
        SEL_C1: begin
          data_d.kind = KIND_PASS;
          data_d.b    = ext(data_i.e1.b);
          data_d.r    = ext(data_i.e1.r);
          data_d.g    = ext(data_i.e1.g);
        end
        SEL_MIX: begin
          if (data_i.four_mode) begin
            // blue keeps the unweighted sum
            data_d.kind = KIND_DIV3;
            data_d.b    = ext(data_i.e0.b) + ext(data_i.e1.b) + NUM_W'(1);
            data_d.r    = dbl(data_i.e0.r) + ext(data_i.e1.r) + NUM_W'(1);
            data_d.g    = dbl(data_i.e0.g) + ext(data_i.e1.g) + NUM_W'(1);
          end else begin
            data_d.kind = KIND_DIV2;
            data_d.b    = ext(data_i.e0.b) + ext(data_i.e1.b);
            data_d.r    = ext(data_i.e0.r) + ext(data_i.e1.r);
            data_d.g    = ext(data_i.e0.g) + ext(data_i.e1.g);
          end
        end
        SEL_ALT: begin
          if (data_i.four_mode) begin
            data_d.kind = KIND_DIV3;
            data_d.b    = ext(data_i.e0.b) + dbl(data_i.e1.b) + NUM_W'(1);
            data_d.r    = ext(data_i.e0.r) + dbl(data_i.e1.r) + NUM_W'(1);
            data_d.g    = ext(data_i.e0.g) + dbl(data_i.e1.g) + NUM_W'(1);
          end
        end
        default: begin
          data_d.kind = KIND_ZERO;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/bc1td_scale.sv =====
`timescale 1ns / 1ps

module bc1td_scale import bc1td_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  blend_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output texel_t data_o
);

  // sums stay below 768, so the reciprocal product floors exactly
  function automatic logic [CHAN_W-1:0] div3(input logic [NUM_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = {{(PROD_W-NUM_W){1'b0}}, v} * {{(PROD_W-NUM_W){1'b0}}, RECIP3};
    return prod[RECIP3_SHIFT +: CHAN_W];
  endfunction

  logic   valid_q;
  texel_t data_d, data_q;
  logic   load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    case (data_i.kind)
      KIND_PASS: begin
        data_d.b = data_i.b[CHAN_W-1:0];
        data_d.r = data_i.r[CHAN_W-1:0];
        data_d.g = data_i.g[CHAN_W-1:0];
        data_d.a = ALPHA_OPAQUE;
      end
      KIND_DIV3: begin
        data_d.b = div3(data_i.b);
        data_d.r = div3(data_i.r);
        data_d.g = div3(data_i.g);
        data_d.a = ALPHA_OPAQUE;
      end
      KIND_DIV2: begin
        data_d.b = data_i.b[CHAN_W:1];
        data_d.r = data_i.r[CHAN_W:1];
        data_d.g = data_i.g[CHAN_W:1];
        data_d.a = ALPHA_OPAQUE;
      end
      default: begin
        data_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bc1td_pkg::*;

  localparam int N_DIR      = 22;
  localparam int N_RAND     = 1000;
  localparam int PHASE_LEN  = 250;
  localparam int DRAIN_WAIT = 8;
  localparam int WDOG_LIMIT = 5000;

  typedef enum logic [2:0] {
    PH_DIRECT,
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } phase_e;

  typedef struct packed {
    logic        present;
    logic [15:0] ep_a;
    logic [15:0] ep_b;
    logic [31:0] idx;
    logic [1:0]  col;
    logic [1:0]  row;
    logic        typed;
    texel_t      want;
  } texel_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        block_present_i;
  logic [15:0] endpoint_a_i;
  logic [15:0] endpoint_b_i;
  logic [31:0] index_bits_i;
  logic [1:0]  texel_col_i;
  logic [1:0]  texel_row_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  blue_out_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  alpha_out_o;

  bc1_texel_decode_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .block_present_i(block_present_i),
    .endpoint_a_i   (endpoint_a_i),
    .endpoint_b_i   (endpoint_b_i),
    .index_bits_i   (index_bits_i),
    .texel_col_i    (texel_col_i),
    .texel_row_i    (texel_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .blue_out_o     (blue_out_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .alpha_out_o    (alpha_out_o)
  );

  texel_req_t dir_tab [0:N_DIR-1];
  texel_req_t req_q [$];
  texel_t     texel_q [$];
  texel_req_t held_req;
  int         n_total;
  int         n_loaded;
  int         n_sent;
  int         n_checked;
  int         n_errors;
  int         n_blank;
  int         n_four;
  int         n_three;
  int         idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rgb_t widen565(logic [15:0] c);
    rgb_t w;
    w.r = {c[15:11], c[15:13]};
    w.g = {c[10:5], c[10:9]};
    w.b = {c[4:0], c[4:2]};
    return w;
  endfunction

  function automatic logic [7:0] div3(int unsigned s);
    return 8'(s / 3);
  endfunction

  function automatic texel_t decode_texel(texel_req_t q);
    rgb_t   c0;
    rgb_t   c1;
    sel_e   pick;
    logic   four;
    texel_t t;
    t = '0;
    if (!q.present) return t;
    c0   = widen565(q.ep_a);
    c1   = widen565(q.ep_b);
    four = q.ep_a > q.ep_b;
    pick = sel_e'(q.idx[{q.row, q.col, 1'b0} +: 2]);
    t.a  = ALPHA_OPAQUE;
    case (pick)
      SEL_C0: begin
        t.b = c0.b; t.r = c0.r; t.g = c0.g;
      end
      SEL_C1: begin
        t.b = c1.b; t.r = c1.r; t.g = c1.g;
      end
      SEL_MIX: begin
        if (four) begin
          // blue deliberately unweighted in this entry
          t.b = div3(int'(c0.b) + c1.b + 1);
          t.r = div3(2 * int'(c0.r) + c1.r + 1);
          t.g = div3(2 * int'(c0.g) + c1.g + 1);
        end else begin
          t.b = 8'((int'(c0.b) + c1.b) / 2);
          t.r = 8'((int'(c0.r) + c1.r) / 2);
          t.g = 8'((int'(c0.g) + c1.g) / 2);
        end
      end
      default: begin
        if (four) begin
          t.b = div3(int'(c0.b) + 2 * int'(c1.b) + 1);
          t.r = div3(int'(c0.r) + 2 * int'(c1.r) + 1);
          t.g = div3(int'(c0.g) + 2 * int'(c1.g) + 1);
        end else begin
          t = '0;
        end
      end
    endcase
    return t;
  endfunction

  function automatic texel_req_t rand_req();
    texel_req_t r;
    r = '0;
    r.present = ($urandom_range(9) != 0);
    r.ep_a    = 16'($urandom);
    r.ep_b    = 16'($urandom);
    case ($urandom_range(9))
      0: r.ep_b = r.ep_a;
      1: r.ep_b = r.ep_a - 16'd1;
      2: r.ep_b = r.ep_a + 16'd1;
      default: ;
    endcase
    r.idx = $urandom;
    r.col = 2'($urandom_range(3));
    r.row = 2'($urandom_range(3));
    return r;
  endfunction

  function automatic phase_e phase_of(int i);
    if (i < N_DIR) return PH_DIRECT;
    case ((i - N_DIR) / PHASE_LEN)
      0:       return PH_FREE;
      1:       return PH_SEND_IDLE;
      2:       return PH_RECV_STALL;
      default: return PH_BOTH;
    endcase
  endfunction

  function automatic int send_idle_pct(phase_e p);
    case (p)
      PH_SEND_IDLE: return 66;
      PH_BOTH:      return 7;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(phase_e p);
    case (p)
      PH_RECV_STALL: return 66;
      PH_BOTH:       return 7;
      default:       return 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    texel_t want;
    phase_e ph;
    logic   hold;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (texel_q.size() == 0) begin
          $error("texel item with no expectation pending");
          n_errors++;
        end else begin
          want = texel_q.pop_front();
          n_checked++;
          if (blue_out_o !== want.b) begin
            $error("blue_out: expected %0h, got %0h", want.b, blue_out_o);
            n_errors++;
          end
          if (red_out_o !== want.r) begin
            $error("red_out: expected %0h, got %0h", want.r, red_out_o);
            n_errors++;
          end
          if (green_out_o !== want.g) begin
            $error("green_out: expected %0h, got %0h", want.g, green_out_o);
            n_errors++;
          end
          if (alpha_out_o !== want.a) begin
            $error("alpha_out: expected %0h, got %0h", want.a, alpha_out_o);
            n_errors++;
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        texel_q.push_back(held_req.typed ? held_req.want : decode_texel(held_req));
        n_sent++;
        if (!held_req.present) n_blank++;
        else if (held_req.ep_a > held_req.ep_b) n_four++;
        else n_three++;
      end

      ph = phase_of(n_loaded);
      if (!in_valid_i || in_ready_o) begin
        // let the pipe run dry at each phase change
        hold = n_loaded > 0 && ph != phase_of(n_loaded - 1) && texel_q.size() != 0;
        if (n_loaded < n_total && !hold && $urandom_range(99) >= send_idle_pct(ph)) begin
          held_req        = req_q[n_loaded];
          n_loaded++;
          in_valid_i      <= 1'b1;
          block_present_i <= held_req.present;
          endpoint_a_i    <= held_req.ep_a;
          endpoint_b_i    <= held_req.ep_b;
          index_bits_i    <= held_req.idx;
          texel_col_i     <= held_req.col;
          texel_row_i     <= held_req.row;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct(ph));

      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
        $display("bc1_texel_decode_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    block_present_i = 1'b0;
    endpoint_a_i    = '0;
    endpoint_b_i    = '0;
    index_bits_i    = '0;
    texel_col_i     = '0;
    texel_row_i     = '0;
    out_ready_i     = 1'b0;
    n_loaded        = 0;
    n_sent          = 0;
    n_checked       = 0;
    n_errors        = 0;
    n_blank         = 0;
    n_four          = 0;
    n_three         = 0;
    idle_cycles     = 0;
    held_req        = '0;

    // present, ep_a, ep_b, idx, col, row, typed, want as b r g a
    dir_tab = '{
      '{1'b0, 16'hFFFF, 16'h0000, 32'hFFFFFFFF, 2'd3, 2'd3, 1'b1, 32'h00000000},
      '{1'b0, 16'h0000, 16'h0000, 32'h00000000, 2'd0, 2'd0, 1'b1, 32'h00000000},
      '{1'b1, 16'hFFFF, 16'h0000, 32'h00000000, 2'd0, 2'd0, 1'b1, 32'hFFFFFFFF},
      '{1'b1, 16'hFFFF, 16'h0000, 32'h55555555, 2'd3, 2'd3, 1'b1, 32'h000000FF},
      '{1'b1, 16'hFFFF, 16'h0000, 32'hAAAAAAAA, 2'd1, 2'd2, 1'b1, 32'h55AAAAFF},
      '{1'b1, 16'hFFFF, 16'h0000, 32'hFFFFFFFF, 2'd0, 2'd0, 1'b1, 32'h555555FF},
      '{1'b1, 16'h0000, 16'hFFFF, 32'hAAAAAAAA, 2'd2, 2'd1, 1'b1, 32'h7F7F7FFF},
      '{1'b1, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 2'd3, 2'd0, 1'b1, 32'h00000000},
      '{1'b1, 16'h0000, 16'h0000, 32'hFFFFFFFF, 2'd0, 2'd3, 1'b1, 32'h00000000},
      '{1'b1, 16'hFFFF, 16'hFFFF, 32'hAAAAAAAA, 2'd1, 2'd1, 1'b1, 32'hFFFFFFFF},
      '{1'b1, 16'h1234, 16'h1234, 32'hAAAAAAAA, 2'd2, 2'd2, 1'b0, 32'h0},
      '{1'b1, 16'h1235, 16'h1234, 32'hE4E4E4E4, 2'd2, 2'd1, 1'b0, 32'h0},
      '{1'b1, 16'hF800, 16'h07E0, 32'hAAAAAAAA, 2'd0, 2'd1, 1'b0, 32'h0},
      '{1'b1, 16'h001F, 16'hF800, 32'h55555555, 2'd3, 2'd2, 1'b0, 32'h0},
      '{1'b1, 16'hFFFF, 16'hFFFE, 32'hFFFFFFFF, 2'd1, 2'd3, 1'b0, 32'h0},
      '{1'b1, 16'h8000, 16'h7FFF, 32'hAAAAAAAA, 2'd3, 2'd0, 1'b0, 32'h0},
      '{1'b1, 16'h7FFF, 16'h8000, 32'hFFFFFFFF, 2'd2, 2'd3, 1'b1, 32'h00000000},
      '{1'b1, 16'hF81F, 16'h07E0, 32'hC0000000, 2'd3, 2'd3, 1'b0, 32'h0},
      '{1'b1, 16'hF81F, 16'h07E0, 32'h00000003, 2'd0, 2'd0, 1'b0, 32'h0},
      '{1'b1, 16'hF81F, 16'h07E0, 32'h0000000C, 2'd1, 2'd0, 1'b0, 32'h0},
      '{1'b1, 16'h07E0, 16'hF81F, 32'h1B1B1B1B, 2'd2, 2'd2, 1'b0, 32'h0},
      '{1'b0, 16'h1234, 16'h4321, 32'h12345678, 2'd1, 2'd2, 1'b1, 32'h00000000}
    };
    for (int i = 0; i < N_DIR; i++) req_q.push_back(dir_tab[i]);
    for (int i = 0; i < N_RAND; i++) req_q.push_back(rand_req());
    n_total = req_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent < n_total || texel_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("%0d blocks decoded (%0d table rows): %0d four-colour, %0d three-colour, %0d absent",
             n_sent, N_DIR, n_four, n_three, n_blank);
    $display("%0d texels compared under free-running, sender-idle and receiver-stall phases",
             n_checked);
    if (n_errors == 0) begin
      $display("bc1_texel_decode_core: match");
    end else begin
      $display("bc1_texel_decode_core: mismatch");
    end
    $finish;
  end

endmodule
